@@ hw/rtl/ssl_pkg.sv @@
// Shared types and constants of the setpoint slew limiter.
package ssl_pkg;

	localparam int POS_W = 32;
	localparam int DT_W = 20;
	localparam int CFG_W = 31;
	localparam int IDX_W = 1;
	localparam int VEC_W = 40;
	localparam int LIM_W = 40;
	localparam int AW = 64;
	localparam int SCALE_SHIFT = 24;
	localparam int Q_W = 25;

	localparam logic [DT_W-1:0] FIRST_DT_US = DT_W'(50000);
	localparam logic [AW-1:0] US_PER_S = AW'(1000000);

	localparam logic [CFG_W-1:0] MAX_SPEED_RST = CFG_W'(327680);
	localparam logic [CFG_W-1:0] MAX_ACCEL_RST = CFG_W'(196608);

	localparam logic [IDX_W-1:0] REG_MAX_SPEED = 1'b0;
	localparam logic [IDX_W-1:0] REG_MAX_ACCEL = 1'b1;

	typedef enum logic [1:0] {
		ALU_MUL,
		ALU_DIV,
		ALU_SQRT
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} alu_sts_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_QMX,
		S_QDX,
		S_QMY,
		S_QDY,
		S_PREP,
		S_LIM_M1,
		S_LIM_D1,
		S_LIM_M2,
		S_LIM_D2,
		S_DIST_K,
		S_DIST_M,
		S_DIST_R,
		S_VL_SH,
		S_VL_MA,
		S_VL_MB,
		S_VL_R,
		S_CL_CMP,
		S_CL_D,
		S_CL_MX,
		S_CL_MY,
		S_NEXT,
		S_FIN,
		S_RMX,
		S_RDX,
		S_RMY,
		S_RDY,
		S_OUT
	} state_t;

endpackage

@@ hw/rtl/ssl_if.sv @@
// Request and result channel interfaces of the setpoint slew limiter.
interface ssl_req_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] goal_x;
	logic signed [31:0] goal_y;
	logic        [19:0] elapsed_us;
	logic signed [31:0] vehicle_vx;
	logic signed [31:0] vehicle_vy;

	modport source (output valid, goal_x, goal_y, elapsed_us, vehicle_vx, vehicle_vy,
		input ready);
	modport sink (input valid, goal_x, goal_y, elapsed_us, vehicle_vx, vehicle_vy,
		output ready);
endinterface

interface ssl_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] limited_x;
	logic signed [31:0] limited_y;
	logic signed [31:0] rate_x;
	logic signed [31:0] rate_y;

	modport source (output valid, limited_x, limited_y, rate_x, rate_y, input ready);
	modport sink (input valid, limited_x, limited_y, rate_x, rate_y, output ready);
endinterface

@@ hw/rtl/ssl_alu.sv @@
// Shared bit-serial unit: shift-add multiply, restoring divide, integer square root.
module ssl_alu (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ssl_pkg::alu_req_t      req,
	input  logic [ssl_pkg::AW-1:0] a,
	input  logic [ssl_pkg::AW-1:0] b,
	output ssl_pkg::alu_sts_t      sts,
	output logic [ssl_pkg::AW-1:0] res
);
	import ssl_pkg::*;

	localparam int CNT_W = $clog2(AW) + 1;
	localparam logic [CNT_W-1:0] MUL_STEPS = CNT_W'(AW / 2);
	localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(AW);
	localparam logic [CNT_W-1:0] SQRT_STEPS = CNT_W'(AW / 2);

	alu_op_t          op_q;
	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [AW-1:0]    x_q;
	logic [AW-1:0]    y_q;
	logic [AW-1:0]    acc_q;
	logic [AW-1:0]    rem_q;

	logic [AW:0]      trial;
	logic             div_fits;
	logic [AW-1:0]    rsum;
	logic             sq_fits;

	assign trial = {rem_q, x_q[AW-1]};
	assign div_fits = trial >= {1'b0, y_q};
	assign rsum = acc_q + y_q;
	assign sq_fits = x_q >= rsum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= ALU_MUL;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				op_q <= req.op;
				busy_q <= 1'b1;
				case (req.op)
					ALU_MUL:  cnt_q <= MUL_STEPS;
					ALU_DIV:  cnt_q <= DIV_STEPS;
					ALU_SQRT: cnt_q <= SQRT_STEPS;
					default:  cnt_q <= MUL_STEPS;
				endcase
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q <= a;
			rem_q <= '0;
			acc_q <= '0;
			case (req.op)
				ALU_SQRT: y_q <= AW'(1) << (AW - 2);
				default:  y_q <= b;
			endcase
		end else if (busy_q) begin
			case (op_q)
				ALU_MUL: begin
					if (y_q[0])
						acc_q <= acc_q + x_q;
					x_q <= x_q << 1;
					y_q <= y_q >> 1;
				end
				ALU_DIV: begin
					if (div_fits) begin
						rem_q <= AW'(trial - {1'b0, y_q});
						x_q <= {x_q[AW-2:0], 1'b1};
					end else begin
						rem_q <= trial[AW-1:0];
						x_q <= {x_q[AW-2:0], 1'b0};
					end
				end
				ALU_SQRT: begin
					if (sq_fits) begin
						x_q <= x_q - rsum;
						acc_q <= (acc_q >> 1) + y_q;
					end else begin
						acc_q <= acc_q >> 1;
					end
					y_q <= y_q >> 2;
				end
				default: ;
			endcase
		end
	end

	assign res = (op_q == ALU_DIV) ? x_q : acc_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q) else $error("alu started while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("alu done without work");
	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (cnt_q == '0)) else $error("alu count left over");
`endif

endmodule

@@ hw/rtl/setpoint_slew_limiter_2d.sv @@
// Top level of the two-dimensional setpoint slew limiter.
//
// A request carries a raw setpoint (goal_x/y), the time since the previous
// request in microseconds and the vehicle velocity. Each request gives one
// result: the limited setpoint and its velocity, Q16.16, saturated.
// Both channels use valid/ready; a request is taken only while the block is
// idle, and the result is held in its output registers until rsp.ready.
// The limit registers are written through cfg_we/cfg_index/cfg_data while
// the block is idle, a rule for the user that the block does not enforce.
// A later zero-interval request is passed to the output in the next cycle;
// otherwise the step is clamped by the speed, acceleration and stopping
// limits, the first request after reset deriving the previous step from the
// vehicle velocity. All multiplies, divides and square roots share one
// bit-serial unit, and a new request waits until the result is handed off.
// Reset clears the history and the limits return to their defaults; the
// first request then assumes a 50 ms interval. A stalled receiver holds the
// block in its result state, with no request taken.
module setpoint_slew_limiter_2d (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [ssl_pkg::IDX_W-1:0] cfg_index,
	input  logic [ssl_pkg::CFG_W-1:0] cfg_data,
	ssl_req_if.sink                   req,
	ssl_rsp_if.source                 rsp
);
	import ssl_pkg::*;

	localparam logic [1:0] STG_CRUISE = 2'd0;
	localparam logic [1:0] STG_ACCEL = 2'd1;
	localparam logic [1:0] STG_STOP = 2'd2;

	function automatic logic [VEC_W-1:0] abs_v(input logic signed [VEC_W-1:0] v);
		abs_v = v[VEC_W-1] ? VEC_W'(-v) : VEC_W'(v);
	endfunction

	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [VEC_W:0] v);
		if (v > $signed((VEC_W+1)'(32'h7fffffff)))
			sat_pos = 32'sh7fffffff;
		else if (v < -$signed((VEC_W+1)'(33'h080000000)))
			sat_pos = 32'sh80000000;
		else
			sat_pos = v[POS_W-1:0];
	endfunction

	function automatic logic signed [POS_W-1:0] sat_rate(input logic neg,
		input logic [AW-1:0] m);
		if (!neg)
			sat_rate = (m > AW'(32'h7fffffff)) ? 32'sh7fffffff : $signed(m[POS_W-1:0]);
		else
			sat_rate = (m > AW'(33'h080000000)) ? 32'sh80000000 : $signed(-m[POS_W-1:0]);
	endfunction

	state_t                    state_q, state_d, nx;
	logic                      wait_q;
	logic                      op_st, go;
	alu_req_t                  alu_req;
	alu_sts_t                  alu_sts;
	logic [AW-1:0]             alu_a, alu_b, alu_res;

	logic [CFG_W-1:0]          max_speed_q, max_accel_q;
	logic signed [POS_W-1:0]   last_x_q, last_y_q, blast_x_q, blast_y_q;
	logic                      started_q;

	logic signed [POS_W-1:0]   tx_q, ty_q, vx_q, vy_q;
	logic [DT_W-1:0]           d_q;
	logic signed [VEC_W-1:0]   cx_q, cy_q, bx_q, by_q;
	logic [LIM_W-1:0]          lim_q, t_q, len_q, dist_q;
	logic [AW-1:0]             sq_q;
	logic [VEC_W-1:0]          ma_q, mb_q;
	logic [3:0]                sh_q;
	logic [2:0]                k_q;
	logic [1:0]                stg_q;
	logic [Q_W-1:0]            q_q;
	logic signed [POS_W-1:0]   out_x_q, out_y_q, rate_x_q, rate_y_q;

	logic [VEC_W-1:0]          abs_cx, abs_cy;
	logic [VEC_W-1:0]          cmag;
	logic [LIM_W-1:0]          root_len;
	logic signed [POS_W-1:0]   sx, sy;

	assign abs_cx = abs_v(cx_q);
	assign abs_cy = abs_v(cy_q);
	assign cmag = VEC_W'(alu_res >> SCALE_SHIFT);
	assign root_len = alu_res[LIM_W-1:0] << sh_q;
	assign sx = sat_pos((VEC_W+1)'(last_x_q) + (VEC_W+1)'(cx_q));
	assign sy = sat_pos((VEC_W+1)'(last_y_q) + (VEC_W+1)'(cy_q));

	ssl_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (alu_a),
		.b      (alu_b),
		.sts    (alu_sts),
		.res    (alu_res)
	);

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = (state_q == S_OUT);
	assign rsp.limited_x = out_x_q;
	assign rsp.limited_y = out_y_q;
	assign rsp.rate_x = rate_x_q;
	assign rsp.rate_y = rate_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		nx = state_q;
		op_st = 1'b1;
		alu_req.op = ALU_MUL;
		alu_a = '0;
		alu_b = '0;
		case (state_q)
			S_QMX: begin
				alu_a = AW'(abs_v(VEC_W'(vx_q)));
				alu_b = AW'(FIRST_DT_US);
				nx = S_QDX;
			end
			S_QDX: begin
				alu_req.op = ALU_DIV;
				alu_a = alu_res;
				alu_b = US_PER_S;
				nx = S_QMY;
			end
			S_QMY: begin
				alu_a = AW'(abs_v(VEC_W'(vy_q)));
				alu_b = AW'(FIRST_DT_US);
				nx = S_QDY;
			end
			S_QDY: begin
				alu_req.op = ALU_DIV;
				alu_a = alu_res;
				alu_b = US_PER_S;
				nx = S_PREP;
			end
			S_LIM_M1: begin
				alu_a = (stg_q == STG_CRUISE) ? AW'(max_speed_q) : AW'(max_accel_q);
				alu_b = AW'(d_q);
				nx = S_LIM_D1;
			end
			S_LIM_D1: begin
				alu_req.op = ALU_DIV;
				alu_a = alu_res;
				alu_b = US_PER_S;
				nx = (stg_q == STG_CRUISE) ? S_VL_SH : S_LIM_M2;
			end
			S_LIM_M2: begin
				alu_a = AW'(t_q);
				alu_b = AW'(d_q);
				nx = S_LIM_D2;
			end
			S_LIM_D2: begin
				alu_req.op = ALU_DIV;
				alu_a = alu_res;
				alu_b = US_PER_S;
				nx = S_VL_SH;
			end
			S_DIST_M: begin
				alu_a = AW'(max_accel_q);
				alu_b = AW'(dist_q[31:0]);
				nx = S_DIST_R;
			end
			S_DIST_R: begin
				alu_req.op = ALU_SQRT;
				alu_a = alu_res;
				nx = S_LIM_M2;
			end
			S_VL_MA: begin
				alu_a = AW'(ma_q);
				alu_b = AW'(ma_q);
				nx = S_VL_MB;
			end
			S_VL_MB: begin
				alu_a = AW'(mb_q);
				alu_b = AW'(mb_q);
				nx = S_VL_R;
			end
			S_VL_R: begin
				alu_req.op = ALU_SQRT;
				alu_a = sq_q;
				nx = S_CL_CMP;
			end
			S_CL_D: begin
				alu_req.op = ALU_DIV;
				alu_a = AW'(lim_q) << SCALE_SHIFT;
				alu_b = AW'(len_q);
				nx = S_CL_MX;
			end
			S_CL_MX: begin
				alu_a = AW'(abs_cx);
				alu_b = AW'(q_q);
				nx = S_CL_MY;
			end
			S_CL_MY: begin
				alu_a = AW'(abs_cy);
				alu_b = AW'(q_q);
				nx = S_NEXT;
			end
			S_RMX: begin
				alu_a = AW'(abs_cx);
				alu_b = US_PER_S;
				nx = S_RDX;
			end
			S_RDX: begin
				alu_req.op = ALU_DIV;
				alu_a = alu_res;
				alu_b = AW'(d_q);
				nx = S_RMY;
			end
			S_RMY: begin
				alu_a = AW'(abs_cy);
				alu_b = US_PER_S;
				nx = S_RDY;
			end
			S_RDY: begin
				alu_req.op = ALU_DIV;
				alu_a = alu_res;
				alu_b = AW'(d_q);
				nx = S_OUT;
			end
			S_IDLE: begin
				op_st = 1'b0;
				if (req.valid) begin
					if (started_q && req.elapsed_us == '0)
						state_d = S_OUT;
					else if (!started_q)
						state_d = S_QMX;
					else
						state_d = S_PREP;
				end
			end
			S_PREP: begin
				op_st = 1'b0;
				state_d = S_LIM_M1;
			end
			S_VL_SH: begin
				op_st = 1'b0;
				if ((ma_q >> 31) == '0 && (mb_q >> 31) == '0)
					state_d = S_VL_MA;
			end
			S_CL_CMP: begin
				op_st = 1'b0;
				state_d = (len_q > lim_q) ? S_CL_D : S_NEXT;
			end
			S_NEXT: begin
				op_st = 1'b0;
				case (stg_q)
					STG_CRUISE: state_d = S_LIM_M1;
					STG_ACCEL:  state_d = S_DIST_K;
					default:    state_d = S_FIN;
				endcase
			end
			S_DIST_K: begin
				op_st = 1'b0;
				if (dist_q[LIM_W-1:32] == '0)
					state_d = S_DIST_M;
			end
			S_FIN: begin
				op_st = 1'b0;
				state_d = S_RMX;
			end
			S_OUT: begin
				op_st = 1'b0;
				if (rsp.ready)
					state_d = S_IDLE;
			end
			default: begin
				op_st = 1'b0;
				state_d = S_IDLE;
			end
		endcase
		alu_req.start = op_st && !wait_q;
		go = op_st && wait_q && alu_sts.done;
		if (go)
			state_d = nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_q <= 1'b0;
			max_speed_q <= MAX_SPEED_RST;
			max_accel_q <= MAX_ACCEL_RST;
			last_x_q <= '0;
			last_y_q <= '0;
			blast_x_q <= '0;
			blast_y_q <= '0;
			started_q <= 1'b0;
		end else begin
			if (alu_req.start)
				wait_q <= 1'b1;
			else if (go)
				wait_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_MAX_SPEED: max_speed_q <= cfg_data;
					REG_MAX_ACCEL: max_accel_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == S_RDY && go) begin
				blast_x_q <= last_x_q;
				blast_y_q <= last_y_q;
				last_x_q <= out_x_q;
				last_y_q <= out_y_q;
				started_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				tx_q <= req.goal_x;
				ty_q <= req.goal_y;
				vx_q <= req.vehicle_vx;
				vy_q <= req.vehicle_vy;
				d_q <= started_q ? req.elapsed_us : FIRST_DT_US;
				bx_q <= VEC_W'(last_x_q) - VEC_W'(blast_x_q);
				by_q <= VEC_W'(last_y_q) - VEC_W'(blast_y_q);
				out_x_q <= req.goal_x;
				out_y_q <= req.goal_y;
				rate_x_q <= '0;
				rate_y_q <= '0;
			end
			S_QDX: if (go)
				bx_q <= vx_q[POS_W-1] ? -$signed(alu_res[VEC_W-1:0]) : $signed(alu_res[VEC_W-1:0]);
			S_QDY: if (go)
				by_q <= vy_q[POS_W-1] ? -$signed(alu_res[VEC_W-1:0]) : $signed(alu_res[VEC_W-1:0]);
			S_PREP: begin
				cx_q <= VEC_W'(tx_q) - VEC_W'(last_x_q);
				cy_q <= VEC_W'(ty_q) - VEC_W'(last_y_q);
				stg_q <= STG_CRUISE;
			end
			S_LIM_D1: if (go) begin
				if (stg_q == STG_CRUISE) begin
					lim_q <= alu_res[LIM_W-1:0];
					ma_q <= abs_cx;
					mb_q <= abs_cy;
					sh_q <= '0;
				end else begin
					t_q <= alu_res[LIM_W-1:0];
				end
			end
			S_LIM_D2: if (go) begin
				lim_q <= alu_res[LIM_W-1:0];
				ma_q <= abs_cx;
				mb_q <= abs_cy;
				sh_q <= '0;
			end
			S_VL_SH: if ((ma_q >> 31) != '0 || (mb_q >> 31) != '0) begin
				ma_q <= ma_q >> 1;
				mb_q <= mb_q >> 1;
				sh_q <= sh_q + 1'b1;
			end
			S_VL_MA: if (go)
				sq_q <= alu_res;
			S_VL_MB: if (go)
				sq_q <= sq_q + alu_res;
			S_VL_R: if (go) begin
				len_q <= root_len;
				if (stg_q == STG_CRUISE)
					dist_q <= root_len;
			end
			S_CL_D: if (go)
				q_q <= alu_res[Q_W-1:0];
			S_CL_MX: if (go)
				cx_q <= cx_q[VEC_W-1] ? -$signed(cmag) : $signed(cmag);
			S_CL_MY: if (go)
				cy_q <= cy_q[VEC_W-1] ? -$signed(cmag) : $signed(cmag);
			S_NEXT: begin
				case (stg_q)
					STG_CRUISE: begin
						cx_q <= cx_q - bx_q;
						cy_q <= cy_q - by_q;
						stg_q <= STG_ACCEL;
					end
					STG_ACCEL: begin
						cx_q <= cx_q + bx_q;
						cy_q <= cy_q + by_q;
						stg_q <= STG_STOP;
						k_q <= '0;
					end
					default: ;
				endcase
			end
			S_DIST_K: if (dist_q[LIM_W-1:32] != '0) begin
				dist_q <= dist_q >> 2;
				k_q <= k_q + 1'b1;
			end
			S_DIST_R: if (go)
				t_q <= (alu_res[LIM_W-1:0] << k_q) << 1;
			S_FIN: begin
				out_x_q <= sx;
				out_y_q <= sy;
				cx_q <= VEC_W'(sx) - VEC_W'(last_x_q);
				cy_q <= VEC_W'(sy) - VEC_W'(last_y_q);
			end
			S_RDX: if (go)
				rate_x_q <= sat_rate(cx_q[VEC_W-1], alu_res);
			S_RDY: if (go)
				rate_y_q <= sat_rate(cy_q[VEC_W-1], alu_res);
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_started_holds: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |=> started_q) else $error("history flag dropped");
	a_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		alu_sts.done |-> wait_q) else $error("unexpected alu result");
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (!wait_q && !alu_sts.busy)) else $error("alu busy while idle");
`endif

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench of the two-dimensional setpoint slew limiter.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import ssl_pkg::*;

	localparam int STALL_LIMIT = 40000;
	localparam longint unsigned ONE_S_US = 1000000;

	typedef struct packed {
		logic signed [31:0] goal_x;
		logic signed [31:0] goal_y;
		logic        [19:0] elapsed_us;
		logic signed [31:0] vehicle_vx;
		logic signed [31:0] vehicle_vy;
	} request_t;

	typedef struct packed {
		logic signed [31:0] limited_x;
		logic signed [31:0] limited_y;
		logic signed [31:0] rate_x;
		logic signed [31:0] rate_y;
	} setpoint_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]  cfg_data;

	ssl_req_if req ();
	ssl_rsp_if rsp ();

	setpoint_slew_limiter_2d i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req.sink),
		.rsp       (rsp.source)
	);

	request_t  pending_requests[$];
	setpoint_t expected_setpoints[$];
	int        mismatches;
	int        stall_cycles;
	bit        no_idle;

	// predictor state
	longint unsigned speed_limit, accel_limit;
	longint          hist_x, hist_y, prev_x, prev_y;
	bit              seeded;
	longint          walk_x, walk_y;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint unsigned mag(longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - r - b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned vec_length(longint x, longint y);
		longint unsigned a, b;
		int s;
		a = mag(x);
		b = mag(y);
		s = 0;
		while ((a >> s) >= (64'd1 << 31) || (b >> s) >= (64'd1 << 31))
			s++;
		a >>= s;
		b >>= s;
		return int_sqrt(a * a + b * b) << s;
	endfunction

	function automatic longint scale_by(longint c, longint unsigned q);
		longint unsigned r;
		r = (mag(c) * q) >> SCALE_SHIFT;
		return c < 0 ? -longint'(r) : longint'(r);
	endfunction

	function automatic void clamp_length(inout longint x, inout longint y,
			input longint unsigned lim);
		longint unsigned len, q;
		len = vec_length(x, y);
		if (len > lim) begin
			q = (lim << SCALE_SHIFT) / len;
			x = scale_by(x, q);
			y = scale_by(y, q);
		end
	endfunction

	function automatic setpoint_t limit_setpoint(request_t it);
		setpoint_t res;
		longint tx, ty, px, py, qx, qy, dx, dy, ax, ay, bx, by, sx, sy;
		longint unsigned d, lim, t, span, spd;
		int k;
		tx = it.goal_x;
		ty = it.goal_y;
		d = it.elapsed_us;
		px = hist_x;
		py = hist_y;
		k = 0;
		if (seeded && d == 0) begin
			res.limited_x = it.goal_x;
			res.limited_y = it.goal_y;
			res.rate_x = '0;
			res.rate_y = '0;
			return res;
		end
		if (!seeded) begin
			d = 50000;
			qx = px - longint'(it.vehicle_vx) * 50000 / 1000000;
			qy = py - longint'(it.vehicle_vy) * 50000 / 1000000;
		end else begin
			qx = prev_x;
			qy = prev_y;
		end
		dx = tx - px;
		dy = ty - py;
		clamp_length(dx, dy, speed_limit * d / ONE_S_US);
		bx = px - qx;
		by = py - qy;
		ax = dx - bx;
		ay = dy - by;
		t = accel_limit * d / ONE_S_US;
		clamp_length(ax, ay, t * d / ONE_S_US);
		dx = bx + ax;
		dy = by + ay;
		span = vec_length(px - tx, py - ty);
		while (span >= (64'd1 << 32)) begin
			span >>= 2;
			k++;
		end
		spd = int_sqrt(accel_limit * span) << k;
		lim = 2 * spd * d / ONE_S_US;
		clamp_length(dx, dy, lim);
		sx = sat32(px + dx);
		sy = sat32(py + dy);
		res.limited_x = sx[31:0];
		res.limited_y = sy[31:0];
		res.rate_x = 32'(sat32((sx - px) * 1000000 / longint'(d)));
		res.rate_y = 32'(sat32((sy - py) * 1000000 / longint'(d)));
		prev_x = px;
		prev_y = py;
		hist_x = sx;
		hist_y = sy;
		seeded = 1'b1;
		return res;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.goal_x <= '0;
			req.goal_y <= '0;
			req.elapsed_us <= '0;
			req.vehicle_vx <= '0;
			req.vehicle_vy <= '0;
		end else if (!req.valid || req.ready) begin
			if (pending_requests.size() > 0 && (no_idle || $urandom_range(99) >= 14)) begin
				request_t it;
				it = pending_requests.pop_front();
				req.valid <= 1'b1;
				req.goal_x <= it.goal_x;
				req.goal_y <= it.goal_y;
				req.elapsed_us <= it.elapsed_us;
				req.vehicle_vx <= it.vehicle_vx;
				req.vehicle_vy <= it.vehicle_vy;
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp.ready <= 1'b0;
		else
			rsp.ready <= no_idle || $urandom_range(99) >= 14;
	end

	// monitor and checker
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				if (expected_setpoints.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result x=%0d y=%0d", rsp.limited_x, rsp.limited_y);
				end else begin
					setpoint_t e;
					e = expected_setpoints.pop_front();
					if (rsp.limited_x !== e.limited_x || rsp.limited_y !== e.limited_y ||
							rsp.rate_x !== e.rate_x || rsp.rate_y !== e.rate_y) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp pos %0d,%0d rate %0d,%0d got pos %0d,%0d rate %0d,%0d",
								e.limited_x, e.limited_y, e.rate_x, e.rate_y,
								rsp.limited_x, rsp.limited_y, rsp.rate_x, rsp.rate_y);
					end
				end
			end
			if (req.valid && req.ready) begin
				request_t it;
				it.goal_x = req.goal_x;
				it.goal_y = req.goal_y;
				it.elapsed_us = req.elapsed_us;
				it.vehicle_vx = req.vehicle_vx;
				it.vehicle_vy = req.vehicle_vy;
				expected_setpoints.push_back(limit_setpoint(it));
			end
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task automatic write_limit(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx == REG_MAX_SPEED)
			speed_limit = value;
		else
			accel_limit = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (pending_requests.size() > 0 || expected_setpoints.size() > 0 || req.valid)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send(int tx, int ty, int dt, int vx, int vy);
		request_t it;
		it.goal_x = tx;
		it.goal_y = ty;
		it.elapsed_us = 20'(dt);
		it.vehicle_vx = vx;
		it.vehicle_vy = vy;
		pending_requests.push_back(it);
	endtask

	task automatic send_random();
		int mode, dt;
		mode = $urandom_range(99);
		if (mode < 6)
			dt = 0;
		else if (mode < 16)
			dt = $urandom_range(1000000);
		else
			dt = $urandom_range(100000, 10000);
		if (mode >= 90) begin
			send($urandom, $urandom, dt, $urandom, $urandom);
		end else begin
			walk_x += $signed($urandom_range(1310720)) - 655360;
			walk_y += $signed($urandom_range(1310720)) - 655360;
			if ($urandom_range(19) == 0) begin
				walk_x = $signed($urandom);
				walk_y = $signed($urandom);
			end
			walk_x = sat32(walk_x);
			walk_y = sat32(walk_y);
			send(int'(walk_x), int'(walk_y), dt, $urandom, $urandom);
		end
	endtask

	initial begin
		logic [CFG_W-1:0] speeds[6], accels[6];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatches = 0;
		stall_cycles = 0;
		no_idle = 1'b0;
		speed_limit = MAX_SPEED_RST;
		accel_limit = MAX_ACCEL_RST;
		hist_x = 0;
		hist_y = 0;
		prev_x = 0;
		prev_y = 0;
		seeded = 1'b0;
		walk_x = 0;
		walk_y = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// first request: seeded from vehicle velocity, interval ignored
		send(32'sh0005_0000, -32'sh0003_0000, 0, 32'sh8000_0000, 32'sh7fff_ffff);
		send(32'sh0005_0000, -32'sh0003_0000, 0, 0, 0);
		send(32'sh7fff_ffff, 32'sh8000_0000, 50000, 0, 0);
		send(32'sh8000_0000, 32'sh7fff_ffff, 1000000, -1, -1);
		send(32'sh0001_0000, 32'sh0001_0000, 1, 0, 0);
		send(0, 0, 999999, 0, 0);
		drain();
		// zero distance to target
		send(int'(hist_x), int'(hist_y), 50000, 0, 0);
		send(int'(hist_x), int'(hist_y), 20000, 0, 0);
		drain();
		write_limit(REG_MAX_SPEED, '1);
		write_limit(REG_MAX_ACCEL, '1);
		send(32'sh7fff_ffff, 32'sh7fff_ffff, 1000000, 0, 0);
		send(32'sh8000_0000, 32'sh8000_0000, 1000000, 0, 0);
		send(32'sh8000_0000, 32'sh7fff_ffff, 1000000, 0, 0);
		send(0, 0, 1, 0, 0);
		drain();
		write_limit(REG_MAX_SPEED, '0);
		write_limit(REG_MAX_ACCEL, '0);
		send(32'sh0010_0000, 32'sh0010_0000, 50000, 0, 0);
		send(32'sh0010_0000, 32'sh0010_0000, 0, 0, 0);
		drain();

		speeds = '{MAX_SPEED_RST, '1, '0, 31'd65536, CFG_W'($urandom), '1};
		accels = '{MAX_ACCEL_RST, '1, '0, 31'd65536, CFG_W'($urandom), '0};
		for (int ph = 0; ph < 6; ph++) begin
			write_limit(REG_MAX_SPEED, speeds[ph]);
			write_limit(REG_MAX_ACCEL, accels[ph]);
			no_idle = (ph == 2);
			for (int n = 0; n < 130; n++)
				send_random();
			drain();
		end

		repeat (50) @(posedge clk);
		if (mismatches == 0 && expected_setpoints.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
